>>> design/gif_frame_compositor_defines.svh
// assertion macros for the frame compositor
`ifndef GIF_FRAME_COMPOSITOR_DEFINES_SVH
`define GIF_FRAME_COMPOSITOR_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define GFC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define GFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/gfc_pkg.sv
`timescale 1ns / 1ps
package gfc_pkg;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_NO_FRAME = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  localparam logic [2:0] DISP_BG   = 3'd2;
  localparam logic [2:0] DISP_PREV = 3'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        start_of_loop;
    logic [8:0]  left;
    logic [8:0]  top;
    logic [8:0]  frame_width;
    logic [8:0]  frame_height;
    logic [2:0]  disposal;
    logic [31:0] pixel;
    logic [7:0]  read_x;
    logic [7:0]  read_y;
  } gfc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_pixel;
    logic        frame_done;
  } gfc_out_t;

  // per-channel s + round(d*inv/255), 8-bit wrap
  function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] inv);
    logic [16:0] p;
    logic [16:0] q;
    begin
      p = 17'(d) * 17'(inv) + 17'd127;
      q = (p + 17'(p >> 8) + 17'd1) >> 8;
      blend_ch = s + q[7:0];
    end
  endfunction

  function automatic logic [31:0] blend(input logic [31:0] s, input logic [31:0] d);
    logic [7:0] inv;
    begin
      inv = 8'd255 - s[31:24];
      for (int i = 0; i < 4; i++) blend[i*8 +: 8] = blend_ch(s[i*8 +: 8], d[i*8 +: 8], inv);
    end
  endfunction

endpackage

>>> design/gfc_stream_if.sv
`timescale 1ns / 1ps
interface gfc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/gif_frame_compositor.sv
// gif frame compositor: canvas of premultiplied bgra pixels in block memory
// in_if carries one transaction per command (begin frame, pixel, read);
// out_if returns exactly one result transaction per command
// cfg_we_i/cfg_idx_i/cfg_data_i write canvas width, height and background;
// the user writes them only while the block is idle, which the block does not enforce
// one transaction is worked on at a time; the canvas memory has a registered
// read, so a pixel or read steps through read, modify/write and
// result; a begin frame sweeps the canvas: a loop start or background
// disposal writes one pixel a cycle over the area, a restore or save copies
// every memory word (2**(XW+YW)) through the memory ports, each word read
// then written, bounded by the copy counter
// reset clears the frame record, saved flag and registers; canvas contents
// stay undefined until written
// a stalled receiver holds the result register and the input stays
// unready until the result is taken
`timescale 1ns / 1ps
module gif_frame_compositor
  import gfc_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfc_stream_if.sink   in_if,
  gfc_stream_if.source out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  `include "gif_frame_compositor_defines.svh"

  localparam int XW = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = XW + YW;
  localparam int DEPTH = 1 << AW;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_CPRD  = 3'd2;
  localparam logic [2:0] S_CPWR  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_PXWR  = 3'd5;
  localparam logic [2:0] S_RDWT  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [31:0] canvas_mem [DEPTH];
  logic [31:0] saved_mem [DEPTH];

  logic [8:0]  cw_q, ch_q;
  logic [31:0] bg_q;
  logic [2:0]  state_q;
  gfc_in_t     req_q;
  gfc_out_t    res_q;
  logic        saved_valid_q, frame_open_q;
  logic [8:0]  prev_left_q, prev_top_q, prev_width_q, prev_height_q;
  logic [2:0]  prev_disp_q;
  logic [8:0]  pos_x_q, pos_y_q;
  logic [9:0]  fx_q, fy_q;          // fill cursor
  logic [9:0]  fx0_q, fx1_q, fy1_q; // fill bounds (exclusive ends)
  logic [AW-1:0] cp_q;              // copy counter
  logic        cp_dir_q;            // 1 restore (saved->canvas), 0 save
  logic        rd_ok_q;
  logic [AW-1:0] pa_q;
  logic [31:0] cv_rd_q, sv_rd_q;

  logic [9:0] ew, eh;
  assign ew = (int'(cw_q) > MAX_WIDTH) ? 10'(MAX_WIDTH) : 10'(cw_q);
  assign eh = (int'(ch_q) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : 10'(ch_q);

  function automatic logic [AW-1:0] addr(input logic [9:0] x, input logic [9:0] y);
    addr = {YW'(y), XW'(x)};
  endfunction

  // canvas memory port control
  logic          cv_we, sv_we;
  logic [AW-1:0] cv_wa, cv_ra, sv_a;
  logic [31:0]   cv_wd;
  always_ff @(posedge clk_i) begin
    if (cv_we) canvas_mem[cv_wa] <= cv_wd;
    cv_rd_q <= canvas_mem[cv_ra];
    if (sv_we) saved_mem[sv_a] <= cv_rd_q;
    sv_rd_q <= saved_mem[sv_a];
  end

  // pixel position and clipping
  logic [9:0] px, py;
  assign px = 10'(prev_left_q) + 10'(pos_x_q);
  assign py = 10'(prev_top_q) + 10'(pos_y_q);
  logic px_in;
  assign px_in = (px < ew) && (py < eh);

  logic acc;
  assign acc = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = (state_q == S_OUT);
  assign out_if.data = res_q;

  logic rect_bad;
  assign rect_bad = (req_q.frame_width == 9'd0) || (req_q.frame_height == 9'd0) ||
                    (10'(req_q.left) > ew) || (10'(req_q.top) > eh) ||
                    (10'(req_q.frame_width) > ew - 10'(req_q.left)) ||
                    (10'(req_q.frame_height) > eh - 10'(req_q.top));

  logic [8:0] nx, ny;
  assign nx = pos_x_q + 9'd1;
  assign ny = pos_y_q + 9'd1;

  always_comb begin
    cv_we = 1'b0;
    cv_wa = addr(fx_q, fy_q);
    cv_wd = bg_q;
    cv_ra = cp_q;
    sv_we = 1'b0;
    sv_a  = cp_q;
    case (state_q)
      S_FILL: cv_we = (fx_q < fx1_q) && (fy_q < fy1_q);
      S_CPWR: begin
        cv_wa = cp_q;
        cv_wd = sv_rd_q;
        cv_we = cp_dir_q;
        sv_we = !cp_dir_q;
      end
      S_IDLE: cv_ra = (in_if.data.cmd == CMD_READ) ?
                      addr(10'(in_if.data.read_x), 10'(in_if.data.read_y)) :
                      addr(px, py);
      S_PXWR: begin
        cv_wa = pa_q;
        cv_wd = blend(req_q.pixel, cv_rd_q);
        cv_we = rd_ok_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= 9'd256; ch_q <= 9'd256; bg_q <= '0;
      state_q <= S_IDLE;
      req_q <= '0; res_q <= '0;
      saved_valid_q <= 1'b0; frame_open_q <= 1'b0;
      prev_left_q <= '0; prev_top_q <= '0; prev_width_q <= '0; prev_height_q <= '0;
      prev_disp_q <= '0; pos_x_q <= '0; pos_y_q <= '0;
      fx_q <= '0; fy_q <= '0; fx0_q <= '0; fx1_q <= '0; fy1_q <= '0;
      cp_q <= '0; cp_dir_q <= 1'b0; rd_ok_q <= 1'b0; pa_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  cw_q <= cfg_data_i[8:0];
          CFG_HEIGHT: ch_q <= cfg_data_i[8:0];
          CFG_BG:     bg_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (acc) begin
          req_q <= in_if.data;
          res_q <= '0;
          rd_ok_q <= 1'b0;
          case (in_if.data.cmd)
            CMD_BEGIN: begin
              frame_open_q <= 1'b0;
              cp_q <= '0;
              if (in_if.data.start_of_loop) begin
                fx0_q <= '0; fx_q <= '0; fy_q <= '0; fx1_q <= ew; fy1_q <= eh;
                state_q <= S_FILL;
              end else if (prev_disp_q == DISP_BG) begin
                fx0_q <= 10'(prev_left_q); fx_q <= 10'(prev_left_q);
                fy_q <= 10'(prev_top_q);
                fx1_q <= (10'(prev_left_q) + 10'(prev_width_q) < ew) ?
                         10'(prev_left_q) + 10'(prev_width_q) : ew;
                fy1_q <= (10'(prev_top_q) + 10'(prev_height_q) < eh) ?
                         10'(prev_top_q) + 10'(prev_height_q) : eh;
                state_q <= S_FILL;
              end else if (prev_disp_q == DISP_PREV && saved_valid_q) begin
                cp_dir_q <= 1'b1;
                state_q <= S_CPRD;
              end else begin
                state_q <= S_CHECK;
              end
            end
            CMD_PIXEL: begin
              if (!frame_open_q) begin
                res_q.status <= ST_NO_FRAME;
                state_q <= S_OUT;
              end else begin
                rd_ok_q <= px_in;
                pa_q <= addr(px, py);
                if (nx >= prev_width_q) begin
                  pos_x_q <= '0;
                  if (ny >= prev_height_q) begin
                    pos_y_q <= '0;
                    frame_open_q <= 1'b0;
                    res_q.frame_done <= 1'b1;
                  end else pos_y_q <= ny;
                end else pos_x_q <= nx;
                state_q <= S_PXWR;
              end
            end
            CMD_READ: begin
              rd_ok_q <= (10'(in_if.data.read_x) < ew) && (10'(in_if.data.read_y) < eh);
              state_q <= S_RDWT;
            end
            default: state_q <= S_OUT;
          endcase
        end
        S_FILL: begin
          // walk the rectangle; an empty rectangle ends at once
          if (fx_q >= fx1_q || fy_q >= fy1_q ||
              (fx_q + 10'd1 >= fx1_q && fy_q + 10'd1 >= fy1_q)) begin
            state_q <= S_CHECK;
          end else if (fx_q + 10'd1 >= fx1_q) begin
            fx_q <= fx0_q; fy_q <= fy_q + 10'd1;
          end else fx_q <= fx_q + 10'd1;
        end
        S_CPRD: state_q <= S_CPWR;
        S_CPWR: begin
          if (cp_q == AW'(DEPTH - 1)) begin
            cp_q <= '0;
            state_q <= cp_dir_q ? S_CHECK : S_OUT;
          end else begin
            cp_q <= cp_q + 1'b1;
            state_q <= S_CPRD;
          end
        end
        S_CHECK: begin
          if (rect_bad) begin
            res_q.status <= ST_REJECT;
            state_q <= S_OUT;
          end else begin
            saved_valid_q <= (req_q.disposal == DISP_PREV);
            prev_left_q <= req_q.left; prev_top_q <= req_q.top;
            prev_width_q <= req_q.frame_width; prev_height_q <= req_q.frame_height;
            prev_disp_q <= req_q.disposal;
            pos_x_q <= '0; pos_y_q <= '0;
            frame_open_q <= 1'b1;
            if (req_q.disposal == DISP_PREV) begin
              cp_dir_q <= 1'b0;
              cp_q <= '0;
              state_q <= S_CPRD;
            end else state_q <= S_OUT;
          end
        end
        S_PXWR: state_q <= S_OUT;
        S_RDWT: begin
          res_q.read_pixel <= rd_ok_q ? cv_rd_q : '0;
          state_q <= S_OUT;
        end
        S_OUT: if (out_if.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // save pass: memory write goes through cv_rd_q, so copy reads lead writes
  `GFC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_if.valid && !out_if.ready,
                   out_if.valid && $stable(out_if.data), "result changed while stalled")
  `GFC_ASSERT_IMPL(a_one_side, clk_i, rst_ni, in_if.ready, !out_if.valid,
                   "input ready while a result waits")
  `GFC_ASSERT_IMPL(a_done_closes, clk_i, rst_ni, out_if.valid && out_if.data.frame_done,
                   !frame_open_q, "frame still open after last pixel")
endmodule

>>> tb/sv/gfc_checker.sv
`timescale 1ns / 1ps
module gfc_checker
  import gfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  gfc_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  gfc_out_t    out_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int MaxW = 256;
  localparam int MaxH = 256;

  bit [31:0] canvas_q [0:MaxW*MaxH-1];
  bit [31:0] saved_q  [0:MaxW*MaxH-1];
  bit [8:0]  screen_w, screen_h;
  bit [31:0] bg_pixel;
  bit        saved_ok, frame_live;
  int        rect_l, rect_t, rect_w, rect_h;
  bit [2:0]  rect_disp;
  int        pos_x, pos_y;

  gfc_out_t  results_q[$];
  int        n_checked = 0;
  int        n_errors = 0;

  assign pending_o = results_q.size();
  assign errors_o = n_errors;

  function automatic int eff_w();
    return (screen_w > MaxW) ? MaxW : int'(screen_w);
  endfunction

  function automatic int eff_h();
    return (screen_h > MaxH) ? MaxH : int'(screen_h);
  endfunction

  function automatic void paint_bg(int x0, int y0, int w, int h);
    for (int y = y0; y < y0 + h && y < eff_h(); y++)
      for (int x = x0; x < x0 + w && x < eff_w(); x++) canvas_q[y*MaxW + x] = bg_pixel;
  endfunction

  // source over destination, premultiplied, per byte with rounding
  function automatic bit [31:0] over(bit [31:0] s, bit [31:0] d);
    int        inv;
    bit [31:0] r;
    inv = 255 - int'(s[31:24]);
    for (int k = 0; k < 4; k++)
      r[k*8 +: 8] = 8'(int'(s[k*8 +: 8]) + (int'(d[k*8 +: 8]) * inv + 127) / 255);
    return r;
  endfunction

  function automatic gfc_out_t compose(gfc_in_t it);
    gfc_out_t r;
    int       w, h, l, t, fw, fh, x, y;
    r = '0;
    w = eff_w();
    h = eff_h();
    case (cmd_e'(it.cmd))
      CMD_BEGIN: begin
        frame_live = 0;
        if (it.start_of_loop) paint_bg(0, 0, w, h);
        else if (rect_disp == DISP_BG) paint_bg(rect_l, rect_t, rect_w, rect_h);
        else if (rect_disp == DISP_PREV && saved_ok) canvas_q = saved_q;
        l = it.left;
        t = it.top;
        fw = it.frame_width;
        fh = it.frame_height;
        if (fw == 0 || fh == 0 || l > w || t > h || fw > w - l || fh > h - t) begin
          r.status = ST_REJECT;
        end else begin
          if (it.disposal == DISP_PREV) saved_q = canvas_q;
          saved_ok = (it.disposal == DISP_PREV);
          rect_l = l;
          rect_t = t;
          rect_w = fw;
          rect_h = fh;
          rect_disp = it.disposal;
          pos_x = 0;
          pos_y = 0;
          frame_live = 1;
        end
      end
      CMD_PIXEL: begin
        if (!frame_live) begin
          r.status = ST_NO_FRAME;
        end else begin
          x = rect_l + pos_x;
          y = rect_t + pos_y;
          // blend dropped outside a shrunken canvas, position still moves
          if (x < w && y < h) canvas_q[y*MaxW + x] = over(it.pixel, canvas_q[y*MaxW + x]);
          pos_x++;
          if (pos_x >= rect_w) begin
            pos_x = 0;
            pos_y++;
            if (pos_y >= rect_h) begin
              pos_y = 0;
              frame_live = 0;
              r.frame_done = 1'b1;
            end
          end
        end
      end
      CMD_READ: begin
        if (int'(it.read_x) < w && int'(it.read_y) < h)
          r.read_pixel = canvas_q[int'(it.read_y)*MaxW + int'(it.read_x)];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    n_errors++;
    $display("[%0t] mismatch on result %0d: %s got %0h want %0h", $time, n_checked, what,
             got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gfc_out_t want;
    if (!rst_ni) begin
      screen_w = 9'd256;
      screen_h = 9'd256;
      bg_pixel = '0;
      saved_ok = 0;
      frame_live = 0;
      rect_l = 0;
      rect_t = 0;
      rect_w = 0;
      rect_h = 0;
      rect_disp = '0;
      pos_x = 0;
      pos_y = 0;
      results_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WIDTH) screen_w = cfg_data_i[8:0];
        else if (cfg_idx_i == CFG_HEIGHT) screen_h = cfg_data_i[8:0];
        else if (cfg_idx_i == CFG_BG) bg_pixel = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (results_q.size() == 0) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          want = results_q.pop_front();
          if (out_data_i.status !== want.status)
            report("status", out_data_i.status, want.status);
          if (out_data_i.read_pixel !== want.read_pixel)
            report("read_pixel", out_data_i.read_pixel, want.read_pixel);
          if (out_data_i.frame_done !== want.frame_done)
            report("frame_done", out_data_i.frame_done, want.frame_done);
        end
        n_checked++;
      end
      if (in_valid_i && in_ready_i) results_q.push_back(compose(in_data_i));
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import gfc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;
  int          errors, pending;

  // stimulus bookkeeping
  int          n_sent;
  int          n_frames;
  bit          calm;          // no idling on either side near the end
  int          stall_left = 0;
  int          cur_w, cur_h;  // effective canvas size as last configured
  bit          loop_ok;       // whole-canvas fill cheap enough for random use

  gfc_stream_if #(.payload_t(gfc_in_t))  in_ch ();
  gfc_stream_if #(.payload_t(gfc_out_t)) out_ch ();

  gif_frame_compositor DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  gfc_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_i (in_ch.ready),
    .in_data_i  (in_ch.data),
    .out_valid_i(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .out_data_i (out_ch.data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop; the slow part is the full-canvas save and restore sweeps
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("tb NOT OK");
    $finish;
  end

  // receiver: random stall bursts, steady ready when calm
  always @(posedge clk_i) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one input transaction, then maybe an idle gap when not calm
  task automatic send(gfc_in_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    n_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // block is idle before any register write
  task automatic setup(int w, int h, logic [31:0] bg);
    drain();
    write_reg(CFG_WIDTH, 32'(w));
    write_reg(CFG_HEIGHT, 32'(h));
    write_reg(CFG_BG, bg);
    cur_w = (w > 256) ? 256 : w;
    cur_h = (h > 256) ? 256 : h;
    loop_ok = (cur_w * cur_h <= 1024);
  endtask

  function automatic gfc_in_t begin_item(bit sol, int l, int t, int w, int h, bit [2:0] d);
    gfc_in_t it;
    it = gfc_in_t'(90'({$urandom(), $urandom(), $urandom()}));
    it.cmd = CMD_BEGIN;
    it.start_of_loop = sol;
    it.left = 9'(l);
    it.top = 9'(t);
    it.frame_width = 9'(w);
    it.frame_height = 9'(h);
    it.disposal = d;
    return it;
  endfunction

  function automatic gfc_in_t pixel_item(logic [31:0] px);
    gfc_in_t it;
    it = gfc_in_t'(90'({$urandom(), $urandom(), $urandom()}));
    it.cmd = CMD_PIXEL;
    it.pixel = px;
    return it;
  endfunction

  function automatic gfc_in_t read_item(int x, int y);
    gfc_in_t it;
    it = gfc_in_t'(90'({$urandom(), $urandom(), $urandom()}));
    it.cmd = CMD_READ;
    it.read_x = 8'(x);
    it.read_y = 8'(y);
    return it;
  endfunction

  // opaque, transparent or random alpha
  function automatic logic [31:0] rand_px();
    logic [31:0] p;
    p = $urandom();
    case ($urandom_range(0, 3))
      0: p[31:24] = 8'hff;
      1: p[31:24] = 8'h00;
      default: ;
    endcase
    return p;
  endfunction

  // any disposal except restore-previous, which costs full-canvas sweeps
  function automatic bit [2:0] cheap_disp();
    bit [2:0] d;
    d = 3'($urandom_range(0, 6));
    return (d >= DISP_PREV) ? d + 3'd1 : d;
  endfunction

  // frame inside the canvas, pixels in raster order with reads mixed in
  task automatic frame_run();
    int       l, t, w, h, n;
    bit       cut;
    bit [2:0] d;
    l = $urandom_range(0, cur_w - 1);
    t = $urandom_range(0, cur_h - 1);
    w = $urandom_range(1, (cur_w - l > 6) ? 6 : cur_w - l);
    h = $urandom_range(1, (cur_h - t > 4) ? 4 : cur_h - t);
    d = cheap_disp();
    cut = ($urandom_range(0, 9) == 0);
    n = cut ? $urandom_range(0, w*h - 1) : w*h;
    send(begin_item(loop_ok && $urandom_range(0, 7) == 0, l, t, w, h, d));
    n_frames++;
    for (int i = 0; i < n; i++) begin
      send(pixel_item(rand_px()));
      if ($urandom_range(0, 5) == 0)
        send(read_item($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1)));
    end
  endtask

  // malformed or stray transactions
  task automatic noise_run();
    gfc_in_t it;
    it = gfc_in_t'(90'({$urandom(), $urandom(), $urandom()}));
    case ($urandom_range(0, 3))
      0: it.cmd = CMD_PIXEL;
      1: it.cmd = CMD_READ;  // may fall outside the canvas
      2: begin
        it.cmd = CMD_BEGIN;
        it.start_of_loop = loop_ok & it.start_of_loop;
        it.disposal = cheap_disp();
      end
      default: it.cmd = CMD_NONE;
    endcase
    send(it);
  endtask

  task automatic random_phase(int count);
    int stop_at;
    stop_at = n_sent + count;
    while (n_sent < stop_at) begin
      if (cur_w > 0 && cur_h > 0 && $urandom_range(0, 99) < 75) frame_run();
      else noise_run();
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    n_sent = 0;
    n_frames = 0;
    calm = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full 256x256 canvas, first begin fills every entry
    setup(256, 256, $urandom());
    send(begin_item(1, 0, 0, 2, 2, DISP_BG));
    send(pixel_item(32'h00ff_ffff));
    send(pixel_item(32'hff00_0000));
    send(pixel_item(32'hffff_ffff));
    send(pixel_item(32'h0000_0000));
    send(read_item(0, 0));
    send(read_item(255, 255));
    send(pixel_item($urandom()));                    // no open frame
    send(begin_item(0, 254, 255, 2, 1, DISP_PREV));  // background disposal, then save
    send(pixel_item(rand_px()));
    send(pixel_item(rand_px()));
    send(read_item(255, 255));
    send(begin_item(0, 0, 0, 1, 1, 3'd7));           // restores saved canvas
    send(read_item(254, 255));
    send(begin_item(0, 0, 0, 0, 5, 3'd1));           // zero width
    send(begin_item(0, 256, 0, 1, 1, 3'd0));         // left at the edge
    send(begin_item(0, 0, 257, 1, 1, 3'd0));         // top past the edge
    send(begin_item(0, 0, 0, 256, 256, 3'd4));       // whole screen, then abandoned
    send(pixel_item(rand_px()));
    send(begin_item(0, 100, 200, 156, 56, 3'd5));    // touches both far edges
    send(gfc_in_t'({CMD_NONE, 1'b1, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff, 3'h7,
                    32'hffff_ffff, 16'hffff}));
    send(read_item(99, 199));

    // hold off until every result is back
    drain();

    // shrink with a frame open so pixels land outside the canvas
    send(begin_item(0, 10, 10, 8, 8, DISP_BG));
    send(pixel_item(rand_px()));
    setup(12, 12, $urandom());
    for (int i = 0; i < 20; i++) send(pixel_item(rand_px()));
    send(read_item(11, 11));
    random_phase(130);

    setup(1, 1, 32'hffff_ffff);
    send(begin_item(1, 0, 0, 1, 1, DISP_BG));
    random_phase(100);

    setup(0, 5, 32'h0);                              // zero width rejects all
    send(begin_item(1, 0, 0, 1, 1, 3'd0));
    random_phase(60);

    setup(511, 300, $urandom());                     // clamps to 256x256
    random_phase(130);

    setup(8, 3, $urandom());
    random_phase(130);

    setup(256, 1, $urandom());
    random_phase(100);

    setup(16, 16, $urandom());
    calm = 1;
    random_phase(120);

    drain();
    repeat (50) @(posedge clk_i);
    $display("sent %0d transactions, %0d frames over 8 canvas settings", n_sent, n_frames);
    $display("covered loop fills, background and restore disposal, blends, reads, rejects");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
